### hdl/zonal_class_remap_core_assert.svh
// Assertion macros used by the core design file.
`ifndef ZONAL_CLASS_REMAP_CORE_ASSERT_SVH
`define ZONAL_CLASS_REMAP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ZCR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ZCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ZCR_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ZCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### hdl/zcr_pkg.sv
// ----------------------------------------------------------------------------
// zcr_pkg
// Types and constants of the zonal class remap core.
// ----------------------------------------------------------------------------
package zcr_pkg;
  localparam int ZoneCount  = 256;
  localparam int ClassCount = 8;
  localparam int ZoneW      = 8;
  localparam int ClassW     = 3;
  localparam int SumW       = 40;
  localparam int EntW       = 4;
  localparam int AddrW      = ZoneW + ClassW;

  localparam logic [1:0] FUNC_ACC   = 2'd0;
  localparam logic [1:0] FUNC_BUILD = 2'd1;
  localparam logic [1:0] FUNC_MAP   = 2'd2;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_MAPPED   = 3'd1;
  localparam logic [2:0] ST_NODATA   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;
  localparam logic [2:0] ST_NOTBUILT = 3'd5;

  localparam logic [1:0] REG_MIN_CLASS = 2'd0;
  localparam logic [1:0] REG_MAX_CLASS = 2'd1;
  localparam logic [1:0] REG_SIM_MAP   = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  zone_id;
    logic [2:0]  class_id;
    logic [31:0] cell_area;
    logic        zone_valid;
    logic        class_valid;
    logic        area_valid;
  } in_item_t;

  typedef struct packed {
    logic [2:0] new_class;
    logic [2:0] status;
  } out_item_t;
endpackage

### hdl/zcr_ram.sv
// ----------------------------------------------------------------------------
// zcr_ram
// Single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module zcr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### hdl/zonal_class_remap_core.sv
// Results: no-data, range, not-built and unknown-zone items and func 3 are registered at
//   the accepting edge; accumulate of a seen zone answers after its sum read and write
//   back, map after its remap read; a zone's first cell clears its sum row before that.
// Throughput: one item at a time; the next item is taken once the result has left.
// Build: walks all zones; a seen zone gets an identity row, then a sort of its sums.
// Reset: min class 0, max class 7, sim map 0, clears seen bits and built flag; RAM kept.
// ----------------------------------------------------------------------------
// zonal_class_remap_core
// Per-zone class area sums, remap table build and cell class remapping.
// ----------------------------------------------------------------------------
`include "zonal_class_remap_core_assert.svh"
module zonal_class_remap_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  zcr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output zcr_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import zcr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACCRD = 4'd1;  // sum read in flight
  localparam logic [3:0] S_ACCWR = 4'd2;  // add and write back
  localparam logic [3:0] S_MAPRD = 4'd3;  // remap entry read in flight
  localparam logic [3:0] S_MAPWR = 4'd4;  // present map result
  localparam logic [3:0] S_ZONE  = 4'd5;  // pick next seen zone
  localparam logic [3:0] S_INIT  = 4'd6;  // write identity row
  localparam logic [3:0] S_IRD   = 4'd7;  // read sum i
  localparam logic [3:0] S_JRD   = 4'd8;  // scan sums j
  localparam logic [3:0] S_ERD   = 4'd9;  // read remap entries i and best
  localparam logic [3:0] S_SWP1  = 4'd10; // read remap entry at best
  localparam logic [3:0] S_SWP2  = 4'd11; // write entries and sums at i
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_CLR   = 4'd13; // zero a newly seen zone's sum row

  logic [3:0] state;
  logic [2:0] min_class, max_class;
  logic [63:0] sim_map;
  logic [ZoneCount-1:0] zone_seen;
  logic built;

  in_item_t cur;
  logic out_full;
  out_item_t out_reg;

  // build walk registers
  logic [ZoneW:0]  zone_ptr;
  logic [ClassW:0] ci, cj, cinit;
  logic [ClassW-1:0] best_cls;
  logic [SumW-1:0] sum_i, best;
  logic found, jpend, erd2;
  logic [EntW-1:0] ent_i;
  logic [ClassW:0] rd_j;

  // sum RAM
  logic             s_we;
  logic [AddrW-1:0] s_wa, s_ra;
  logic [SumW-1:0]  s_wd, s_rd;
  // remap RAM
  logic             r_we;
  logic [AddrW-1:0] r_wa, r_ra;
  logic [EntW-1:0]  r_wd, r_rd;

  zcr_ram #(.Width(SumW), .Depth(ZoneCount * ClassCount)) u_sums (
    .clk(clk), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
    .rd_addr(s_ra), .rd_data(s_rd));
  zcr_ram #(.Width(EntW), .Depth(ZoneCount * ClassCount)) u_remap (
    .clk(clk), .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd),
    .rd_addr(r_ra), .rd_data(r_rd));

  logic [2:0] top;
  assign top = max_class; // class count is 8, so max_class never exceeds the top

  logic in_acc, out_acc;
  assign in_stall  = (state != S_IDLE) || out_full;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_full;
  assign out_item  = out_reg;
  assign out_acc   = out_full && !out_stall;
  assign cfg_ready = (state == S_IDLE);

  logic [ZoneW-1:0] zp;
  assign zp = zone_ptr[ZoneW-1:0];

  logic sim_ij;
  assign sim_ij = sim_map[{ci[ClassW-1:0], cj[ClassW-1:0]}];

  // saturating add; a new zone's row has been zeroed before its first read
  logic [SumW:0] add_full;
  logic [SumW-1:0] acc_sum;
  assign add_full = {1'b0, s_rd} + {9'd0, cur.cell_area};
  assign acc_sum  = add_full[SumW] ? {SumW{1'b1}} : add_full[SumW-1:0];

  always_comb begin
    s_we = 1'b0; s_wa = {cur.zone_id, cur.class_id}; s_wd = acc_sum;
    s_ra = {cur.zone_id, cur.class_id};
    r_we = 1'b0; r_wa = {zp, cinit[ClassW-1:0]}; r_wd = {1'b0, cinit[ClassW-1:0]};
    r_ra = {cur.zone_id, cur.class_id};
    unique case (state)
      S_CLR: begin
        s_we = 1'b1; s_wa = {cur.zone_id, cinit[ClassW-1:0]}; s_wd = '0;
      end
      S_ACCWR: s_we = 1'b1;
      S_INIT:  r_we = 1'b1;
      S_IRD:   s_ra = {zp, ci[ClassW-1:0]};
      S_JRD:   s_ra = {zp, rd_j[ClassW-1:0]};
      S_ERD:   r_ra = erd2 ? {zp, best_cls} : {zp, ci[ClassW-1:0]};
      S_SWP1: begin
        r_ra = {zp, best_cls};
      end
      S_SWP2: begin
        s_we = 1'b1; s_wa = {zp, ci[ClassW-1:0]}; s_wd = best;
        r_we = 1'b1; r_wa = {zp, ci[ClassW-1:0]}; r_wd = r_rd;
      end
      S_OUT: begin
        s_we = 1'b1; s_wa = {zp, best_cls}; s_wd = sum_i;
        r_we = 1'b1; r_wa = {zp, best_cls}; r_wd = ent_i;
      end
      default: ;
    endcase
  end

  // S_OUT is reused as the second swap write; results leave via out_reg.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; min_class <= 3'd0; max_class <= 3'd7; sim_map <= '0;
      zone_seen <= '0; built <= 1'b0; out_full <= 1'b0;
    end else begin
      if (out_acc) out_full <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MIN_CLASS: min_class <= cfg_data[2:0];
          REG_MAX_CLASS: max_class <= cfg_data[2:0];
          REG_SIM_MAP:   sim_map   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_acc) begin
          cur <= in_item;
          priority if (in_item.func == FUNC_ACC) begin
            if (!(in_item.zone_valid && in_item.class_valid && in_item.area_valid)) begin
              out_reg <= '{3'd0, ST_NODATA}; out_full <= 1'b1;
            end else if (in_item.class_id > top) begin
              out_reg <= '{3'd0, ST_RANGE}; out_full <= 1'b1;
            end else if (!zone_seen[in_item.zone_id]) begin
              zone_seen[in_item.zone_id] <= 1'b1;
              cinit <= '0; state <= S_CLR;
            end else begin
              state <= S_ACCRD;
            end
          end else if (in_item.func == FUNC_BUILD) begin
            zone_ptr <= '0; state <= S_ZONE;
          end else if (in_item.func == FUNC_MAP) begin
            if (!(in_item.zone_valid && in_item.class_valid)) begin
              out_reg <= '{3'd0, ST_NODATA}; out_full <= 1'b1;
            end else if (!built) begin
              out_reg <= '{3'd0, ST_NOTBUILT}; out_full <= 1'b1;
            end else if (!zone_seen[in_item.zone_id]) begin
              out_reg <= '{3'd0, ST_UNKNOWN}; out_full <= 1'b1;
            end else if (in_item.class_id < min_class || in_item.class_id > top) begin
              out_reg <= '{3'd0, ST_RANGE}; out_full <= 1'b1;
            end else begin
              state <= S_MAPRD;
            end
          end else begin
            out_reg <= '{3'd0, ST_ACCEPTED}; out_full <= 1'b1;
          end
        end
        S_CLR: begin
          // zero one class of the new row a cycle, then do the add
          if (cinit == ClassCount[ClassW:0] - 1'b1) begin
            state <= S_ACCRD;
          end
          cinit <= cinit + 1'b1;
        end
        S_ACCRD: begin
          state <= S_ACCWR;
        end
        S_ACCWR: begin
          built <= 1'b0;
          out_reg <= '{3'd0, ST_ACCEPTED}; out_full <= 1'b1; state <= S_IDLE;
        end
        S_MAPRD: state <= S_MAPWR;
        S_MAPWR: begin
          out_reg <= '{r_rd[2:0], ST_MAPPED}; out_full <= 1'b1; state <= S_IDLE;
        end
        S_ZONE: begin
          if (zone_ptr == ZoneCount[ZoneW:0]) begin
            built <= 1'b1;
            out_reg <= '{3'd0, ST_ACCEPTED}; out_full <= 1'b1; state <= S_IDLE;
          end else if (zone_seen[zp]) begin
            cinit <= '0; state <= S_INIT;
          end else begin
            zone_ptr <= zone_ptr + 1'b1;
          end
        end
        S_INIT: begin
          if (cinit == ClassCount[ClassW:0] - 1'b1) begin
            ci <= {1'b0, min_class}; state <= S_IRD;
          end
          cinit <= cinit + 1'b1;
        end
        S_IRD: begin
          // issue read of sum i; next cycle it arrives
          if (ci > {1'b0, top}) begin
            zone_ptr <= zone_ptr + 1'b1; state <= S_ZONE;
          end else begin
            cj <= ci + 1'b1; rd_j <= ci + 1'b1; jpend <= 1'b0; found <= 1'b0;
            best_cls <= ci[ClassW-1:0];
            state <= S_JRD; erd2 <= 1'b1;
          end
        end
        S_JRD: begin
          // first cycle here captures sum i (erd2 marks that), then sums j
          if (erd2) begin
            sum_i <= s_rd; best <= s_rd; erd2 <= 1'b0;
            rd_j <= rd_j + 1'b1; jpend <= 1'b1;
          end else if (jpend && cj <= {1'b0, top} && sim_ij) begin
            if (s_rd > best) begin
              best <= s_rd; best_cls <= cj[ClassW-1:0]; found <= 1'b1;
            end
            cj <= cj + 1'b1; rd_j <= rd_j + 1'b1;
          end else if (found) begin
            erd2 <= 1'b0; state <= S_ERD;
          end else begin
            ci <= ci + 1'b1; state <= S_IRD;
          end
        end
        S_ERD: begin
          if (!erd2) begin
            erd2 <= 1'b1;
          end else begin
            ent_i <= r_rd; state <= S_SWP1;
          end
        end
        S_SWP1: state <= S_SWP2;
        S_SWP2: begin
          state <= S_OUT;
        end
        S_OUT: begin
          ci <= ci + 1'b1; state <= S_IRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ZCR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")
  `ZCR_ASSERT_IMPL(a_busy_stall, clk, rst, state != S_IDLE, in_stall, "item taken while busy")
  `ZCR_ASSERT_NEXT(a_acc_done, clk, rst, state == S_ACCWR, out_valid && !built, "accumulate lost")
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives cells, build and map commands into the zonal class remap core and
// checks every answer against an in-bench model of zone sums and remap rows.
// ----------------------------------------------------------------------------
module testbench;
  import zcr_pkg::*;

  localparam logic [39:0] SumCap = 40'hFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  zonal_class_remap_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state: zone sums, remap rows, seen bits and the built flag.
  logic [2:0] lo_cls, hi_cls;
  logic [63:0] sim_bits;
  logic [39:0] zone_sum [ZoneCount][ClassCount];
  logic [3:0] remap_row [ZoneCount][ClassCount];
  logic seen_zone [ZoneCount];
  logic built;

  in_item_t cell_queue [$];
  out_item_t answer_queue [$];
  int send_idle_pct, recv_idle_pct;
  int mismatches;

  // Sort one zone's row: pull the largest of each similar run down to class i.
  function automatic void remap_zone(int z);
    logic [39:0] best;
    int best_cls;
    logic [3:0] t;
    for (int c = 0; c < ClassCount; c++) remap_row[z][c] = 4'(c);
    for (int i = lo_cls; i <= hi_cls; i++) begin
      best = zone_sum[z][i];
      best_cls = i;
      for (int j = i + 1; j <= hi_cls && sim_bits[i*8+j]; j++) begin
        if (zone_sum[z][j] > best) begin
          best = zone_sum[z][j];
          best_cls = j;
        end
      end
      if (best_cls != i) begin
        zone_sum[z][best_cls] = zone_sum[z][i];
        zone_sum[z][i] = best;
        t = remap_row[z][i];
        remap_row[z][i] = remap_row[z][best_cls];
        remap_row[z][best_cls] = t;
      end
    end
  endfunction

  function automatic out_item_t predict_answer(in_item_t c);
    out_item_t r;
    logic [40:0] s;
    r = '0;
    r.status = ST_ACCEPTED;
    if (c.func == FUNC_ACC) begin
      if (!c.zone_valid || !c.class_valid || !c.area_valid) r.status = ST_NODATA;
      else if (c.class_id > hi_cls) r.status = ST_RANGE;
      else begin
        if (!seen_zone[c.zone_id]) begin
          for (int k = 0; k < ClassCount; k++) zone_sum[c.zone_id][k] = '0;
          seen_zone[c.zone_id] = 1'b1;
        end
        s = zone_sum[c.zone_id][c.class_id] + c.cell_area;
        zone_sum[c.zone_id][c.class_id] = s[40] ? SumCap : s[39:0];
        built = 1'b0;
      end
    end else if (c.func == FUNC_BUILD) begin
      for (int z = 0; z < ZoneCount; z++) if (seen_zone[z]) remap_zone(z);
      built = 1'b1;
    end else if (c.func == FUNC_MAP) begin
      if (!c.zone_valid || !c.class_valid) r.status = ST_NODATA;
      else if (!built) r.status = ST_NOTBUILT;
      else if (!seen_zone[c.zone_id]) r.status = ST_UNKNOWN;
      else if (c.class_id < lo_cls || c.class_id > hi_cls) r.status = ST_RANGE;
      else begin
        r.new_class = remap_row[c.zone_id][c.class_id][2:0];
        r.status = ST_MAPPED;
      end
    end
    return r;
  endfunction

  // Driver: hold the item until accepted, then advance or idle.
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (cell_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= cell_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          in_item <= in_item_t'(48'({$urandom, $urandom}));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: predict on acceptance, compare on delivery.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst) begin
      if (in_valid && !in_stall)
        answer_queue.insert(answer_queue.size(), predict_answer(in_item));
      if (out_valid && !out_stall) begin
        if (answer_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected answer %p", out_item);
        end else begin
          e = answer_queue.pop_front();
          if (e.new_class !== out_item.new_class || e.status !== out_item.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected class %0d status %0d, got class %0d status %0d",
                       e.new_class, e.status, out_item.new_class, out_item.status);
          end
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MIN_CLASS) lo_cls = val[2:0];
    else if (idx == REG_MAX_CLASS) hi_cls = val[2:0];
    else sim_bits = val;
  endtask

  // Let the block drain everything, until no stimulus or expected answer is left.
  task automatic drain();
    while (cell_queue.size() > 0 || in_valid || answer_queue.size() > 0) @(posedge clk);
    repeat (20000) @(posedge clk);
  endtask

  function automatic in_item_t make_cell(logic [1:0] f, logic [7:0] z, logic [2:0] c,
                                         logic [31:0] a, logic [2:0] v);
    in_item_t it;
    it.func = f; it.zone_id = z; it.class_id = c; it.cell_area = a;
    {it.zone_valid, it.class_valid, it.area_valid} = v;
    return it;
  endfunction

  // Append one item to the pending stimulus.
  function automatic void queue_cell(in_item_t it);
    cell_queue.insert(cell_queue.size(), it);
  endfunction

  // One random phase: a random mix of accumulates, builds, maps and func 3 items, mostly over four zones.
  task automatic random_phase(int n);
    logic [7:0] zones [4];
    in_item_t it;
    int r;
    for (int k = 0; k < 4; k++) zones[k] = 8'($urandom);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      it = in_item_t'(48'({$urandom, $urandom}));
      it.zone_id = ($urandom_range(9) == 0) ? it.zone_id : zones[$urandom_range(3)];
      {it.zone_valid, it.class_valid, it.area_valid} =
        ($urandom_range(9) == 0) ? 3'($urandom) : 3'b111;
      if ($urandom_range(9) == 0) {it.zone_valid, it.class_valid, it.area_valid} = 3'($urandom);
      if (r < 45) it.func = FUNC_ACC;
      else if (r < 50) it.func = FUNC_BUILD;
      else if (r < 98) it.func = FUNC_MAP;
      else it.func = 2'd3;
      if (it.func == FUNC_ACC && $urandom_range(3) != 0) it.cell_area = $urandom_range(65535);
      if (it.func == FUNC_ACC && $urandom_range(49) == 0) it.cell_area = '1;
      queue_cell(it);
    end
  endtask

  initial begin
    lo_cls = 3'd0; hi_cls = 3'd7; sim_bits = '0; built = 1'b0; mismatches = 0;
    for (int z = 0; z < ZoneCount; z++) seen_zone[z] = 1'b0;
    send_idle_pct = 14; recv_idle_pct = 65;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: map before build, no data cases, extremes.
    write_reg(REG_SIM_MAP, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_cell(make_cell(FUNC_MAP, 8'd0, 3'd0, 0, 3'b111));
    queue_cell(make_cell(FUNC_MAP, 8'd3, 3'd1, 0, 3'b011));
    queue_cell(make_cell(FUNC_MAP, 8'd3, 3'd1, 0, 3'b101));
    queue_cell(make_cell(FUNC_ACC, 8'd0, 3'd0, '1, 3'b110));
    queue_cell(make_cell(FUNC_ACC, 8'd255, 3'd7, '1, 3'b111));
    for (int k = 0; k < 300; k += 40)
      queue_cell(make_cell(FUNC_ACC, 8'd255, 3'd7, '1, 3'b111));
    queue_cell(make_cell(FUNC_ACC, 8'd255, 3'd2, 32'd5, 3'b111));
    queue_cell(make_cell(FUNC_ACC, 8'd0, 3'd1, 32'd9, 3'b111));
    queue_cell(make_cell(FUNC_BUILD, 8'd0, 3'd0, 0, 3'b000));
    for (int c = 0; c < 8; c++)
      queue_cell(make_cell(FUNC_MAP, 8'd255, 3'(c), 0, 3'b110));
    queue_cell(make_cell(FUNC_MAP, 8'd7, 3'd0, 0, 3'b110));
    queue_cell(make_cell(2'd3, 8'd0, 3'd0, 0, 3'b111));
    drain();
    write_reg(REG_MAX_CLASS, 64'd4);
    write_reg(REG_MIN_CLASS, 64'd6);
    queue_cell(make_cell(FUNC_ACC, 8'd0, 3'd6, 1, 3'b111));
    queue_cell(make_cell(FUNC_BUILD, 8'd0, 3'd0, 0, 3'b111));
    queue_cell(make_cell(FUNC_MAP, 8'd0, 3'd3, 0, 3'b111));
    drain();

    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin send_idle_pct = 65; recv_idle_pct = 14; end
      if (p == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_reg(REG_MIN_CLASS, (p % 3 == 0) ? 64'd0 : 64'($urandom_range(7)));
      write_reg(REG_MAX_CLASS, (p % 3 == 0) ? 64'd7 : 64'($urandom_range(7)));
      write_reg(REG_SIM_MAP, (p == 1) ? 64'd0 : {$urandom, $urandom} | {$urandom, $urandom});
      random_phase(140);
      drain();
    end
    if (mismatches == 0 && answer_queue.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("testbench failed");
    $finish;
  end
endmodule
